// ===== hdl/voxel_first_point_filter_assert.svh =====
// Assertion macros for the voxel first-point filter.
`ifndef VOXEL_FIRST_POINT_FILTER_ASSERT_SVH
`define VOXEL_FIRST_POINT_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define VFPF_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("vfpf: check failed");
`define VFPF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) \
        else $error("vfpf: check failed");
`else
`define VFPF_ASSERT(label, prop)
`define VFPF_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hdl/vfpf_pkg.sv =====
// Shared constants, types and state encodings of the voxel first-point filter.
package vfpf_pkg;

    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 20;
    localparam int IDX_W      = 21;
    localparam int KEY_W      = 3 * IDX_W;
    localparam int SEEN_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(SEEN_DEPTH);
    localparam int PROBE_W    = ADDR_W + 1;
    localparam int EPOCH_W    = 4;
    localparam int ENTRY_W    = EPOCH_W + KEY_W;
    localparam int HASH_W     = 41;
    localparam int HASH_CHUNK = 7;
    localparam int HASH_STEPS = 6;
    localparam int DIV_STEPS  = COORD_W;
    localparam int CNT_W      = 5;

    localparam logic [SIZE_W-1:0]  VOXEL_SIZE_RESET = 20'd512;
    localparam logic [IDX_W-1:0]   IDX_BIAS         = 21'h100000;
    localparam logic [HASH_W-1:0]  HASH_MULT        = 41'h1B97F4A7C15;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST      = 4'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST       = 4'd15;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE       = 4'd0;

    typedef enum logic [2:0] {
        F_IDLE, F_DIV, F_KEY, F_HASH, F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_PROBE, B_CHECK, B_EMIT
    } t_back_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [COORD_W-1:0]        stamp;
        logic [KEY_W-1:0]          key;
        logic [ADDR_W-1:0]         slot;
        logic                      cloud_start;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [COORD_W-1:0]        stamp;
        logic [KEY_W-1:0]          key;
        logic                      full;
    } t_result;

    typedef struct packed {
        logic init;
        logic emit;
    } t_back_stat;

endpackage

// ===== hdl/voxel_first_point_filter.sv =====
// Voxel first-point filter: passes the first point seen in each voxel.
//
// Input channel: push/full. An item is taken at an edge with push high and
// full low. Each item carries x, y, z, a timestamp and a cloud-start flag.
// Output channel: empty/pop. While empty is low the oldest result is on the
// o_out_* ports; it leaves at an edge with pop high and empty low.
// Config: i_cfg_we/i_cfg_data write voxel_size (reset 512, 0 acts as 1).
// The front end takes one item at a time: bit-serial division (three lanes in
// parallel), a key step, a hash multiply and a push that waits while the queue
// is full; it takes no new item until the push. The back end probes the table
// slot by slot, then emits; a two-entry queue lets the front work ahead.
// A new key finding a full table probes all 4096 slots.
// After reset the whole table is swept with full held high.
// Each 15th cloud start triggers the same sweep inside the back end.
// A stalled receiver holds the result register; the back end then waits and
// the front end keeps filling the queue until full rises.
`include "voxel_first_point_filter_assert.svh"
module voxel_first_point_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [vfpf_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vfpf_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vfpf_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vfpf_pkg::COORD_W-1:0]        i_stamp,
    input  logic                                i_cloud_start,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [vfpf_pkg::COORD_W-1:0] o_out_x,
    output logic signed [vfpf_pkg::COORD_W-1:0] o_out_y,
    output logic signed [vfpf_pkg::COORD_W-1:0] o_out_z,
    output logic [vfpf_pkg::COORD_W-1:0]        o_out_stamp,
    output logic [vfpf_pkg::KEY_W-1:0]          o_voxel_key,
    output logic                                o_store_full,
    input  logic                                i_cfg_we,
    input  logic [vfpf_pkg::SIZE_W-1:0]         i_cfg_data
);

    logic [vfpf_pkg::SIZE_W-1:0] r_voxel_size;
    logic                        r_out_valid;
    vfpf_pkg::t_result           r_res;
    logic                        front_busy, q_push, q_pop, q_full, q_empty;
    logic [1:0]                  q_count;
    vfpf_pkg::t_item             f_item, q_item;
    vfpf_pkg::t_back_stat        b_stat;
    vfpf_pkg::t_result           b_res;

    assign full = front_busy || b_stat.init;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voxel_size <= vfpf_pkg::VOXEL_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_voxel_size <= i_cfg_data;
        end
    end

    vfpf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push && !full),
        .i_x           (i_coord_x),
        .i_y           (i_coord_y),
        .i_z           (i_coord_z),
        .i_stamp       (i_stamp),
        .i_cloud_start (i_cloud_start),
        .i_size        (r_voxel_size),
        .i_q_full      (q_full),
        .o_busy        (front_busy),
        .o_q_push      (q_push),
        .o_item        (f_item)
    );

    vfpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count),
        .o_item  (q_item)
    );

    vfpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_item     (q_item),
        .i_out_busy (r_out_valid),
        .o_q_pop    (q_pop),
        .o_stat     (b_stat),
        .o_res      (b_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_stat.emit) begin
            r_out_valid <= 1'b1;
        end else if (pop && r_out_valid) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_stat.emit) r_res <= b_res;
    end

    assign empty        = !r_out_valid;
    assign o_out_x      = r_res.x;
    assign o_out_y      = r_res.y;
    assign o_out_z      = r_res.z;
    assign o_out_stamp  = r_res.stamp;
    assign o_voxel_key  = r_res.key;
    assign o_store_full = r_res.full;

    // checks
    `VFPF_ASSERT(a_init_blocks_input, b_stat.init |-> full)
    `VFPF_ASSERT(a_emit_into_free_reg, b_stat.emit |-> !r_out_valid)
    `VFPF_ASSERT_NEXT(a_emit_shows_result, b_stat.emit, !empty)
    `VFPF_ASSERT(a_queue_bound, q_count != 2'd3)

endmodule

// ===== hdl/vfpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vfpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/vfpf_front.sv =====
// Front end: takes a point, floor-divides the coordinates and hashes the voxel key.
module vfpf_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  logic signed [vfpf_pkg::COORD_W-1:0]  i_x,
    input  logic signed [vfpf_pkg::COORD_W-1:0]  i_y,
    input  logic signed [vfpf_pkg::COORD_W-1:0]  i_z,
    input  logic [vfpf_pkg::COORD_W-1:0]         i_stamp,
    input  logic                                 i_cloud_start,
    input  logic [vfpf_pkg::SIZE_W-1:0]          i_size,
    input  logic                                 i_q_full,
    output logic                                 o_busy,
    output logic                                 o_q_push,
    output vfpf_pkg::t_item                      o_item
);

    vfpf_pkg::t_front_state r_state, n_state;
    logic [vfpf_pkg::CNT_W-1:0]    r_cnt;
    logic [vfpf_pkg::SIZE_W-1:0]   r_size;
    logic [vfpf_pkg::COORD_W-1:0]  r_dvd [3];
    logic [vfpf_pkg::SIZE_W-1:0]   r_rem [3];
    logic                          r_neg [3];
    logic signed [vfpf_pkg::COORD_W-1:0] r_x, r_y, r_z;
    logic [vfpf_pkg::COORD_W-1:0]  r_stamp;
    logic                          r_cs;
    logic [vfpf_pkg::KEY_W-1:0]    r_key;
    logic [vfpf_pkg::HASH_W-1:0]   r_g, r_c, r_acc;

    logic [vfpf_pkg::COORD_W-1:0]  w_c [3];
    logic [vfpf_pkg::SIZE_W:0]     w_remw [3];
    logic                          w_ge [3];
    logic [vfpf_pkg::IDX_W-1:0]    w_qmag [3];
    logic [vfpf_pkg::IDX_W-1:0]    w_idx [3];
    logic [vfpf_pkg::KEY_W-1:0]    w_key;
    logic [vfpf_pkg::HASH_W-1:0]   w_g;
    logic [vfpf_pkg::HASH_W+vfpf_pkg::HASH_CHUNK-1:0] w_prod;
    logic [vfpf_pkg::ADDR_W-1:0]   w_slot;

    assign w_c[0] = i_x;
    assign w_c[1] = i_y;
    assign w_c[2] = i_z;

    // one restoring divide step per lane, and the final index per lane
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_remw[l] = {r_rem[l], r_dvd[l][vfpf_pkg::COORD_W-1]};
            w_ge[l]   = (w_remw[l] >= {1'b0, r_size});
            w_qmag[l] = r_dvd[l][vfpf_pkg::IDX_W-1:0]
                      + vfpf_pkg::IDX_W'(r_neg[l] && (r_rem[l] != '0));
            w_idx[l]  = (r_neg[l] ? vfpf_pkg::IDX_W'(-w_qmag[l]) : w_qmag[l])
                      ^ vfpf_pkg::IDX_BIAS;
        end
    end

    // key packing, hash fold, slot
    assign w_key  = {w_idx[2], w_idx[1], w_idx[0]};
    assign w_g    = w_key[vfpf_pkg::HASH_W-1:0]
                  ^ vfpf_pkg::HASH_W'(w_key >> vfpf_pkg::IDX_W)
                  ^ vfpf_pkg::HASH_W'(w_key >> (2 * vfpf_pkg::IDX_W));
    assign w_prod = r_g[vfpf_pkg::HASH_CHUNK-1:0] * r_c;
    assign w_slot = r_acc[vfpf_pkg::ADDR_W-1:0]
                  ^ r_acc[29 +: vfpf_pkg::ADDR_W];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vfpf_pkg::F_IDLE: if (i_push) n_state = vfpf_pkg::F_DIV;
            vfpf_pkg::F_DIV:  if (r_cnt == vfpf_pkg::CNT_W'(vfpf_pkg::DIV_STEPS - 1))
                                  n_state = vfpf_pkg::F_KEY;
            vfpf_pkg::F_KEY:  n_state = vfpf_pkg::F_HASH;
            vfpf_pkg::F_HASH: if (r_cnt == vfpf_pkg::CNT_W'(vfpf_pkg::HASH_STEPS - 1))
                                  n_state = vfpf_pkg::F_PUSH;
            vfpf_pkg::F_PUSH: if (!i_q_full) n_state = vfpf_pkg::F_IDLE;
            default:          n_state = vfpf_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy   = (r_state != vfpf_pkg::F_IDLE);
        o_q_push = (r_state == vfpf_pkg::F_PUSH) && !i_q_full;
        o_item.x           = r_x;
        o_item.y           = r_y;
        o_item.z           = r_z;
        o_item.stamp       = r_stamp;
        o_item.key         = r_key;
        o_item.slot        = w_slot;
        o_item.cloud_start = r_cs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfpf_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            vfpf_pkg::F_IDLE: begin
                r_cnt   <= '0;
                r_size  <= (i_size == '0) ? vfpf_pkg::SIZE_W'(1) : i_size;
                r_x     <= i_x;
                r_y     <= i_y;
                r_z     <= i_z;
                r_stamp <= i_stamp;
                r_cs    <= i_cloud_start;
                for (int l = 0; l < 3; l++) begin
                    r_neg[l] <= w_c[l][vfpf_pkg::COORD_W-1];
                    r_dvd[l] <= w_c[l][vfpf_pkg::COORD_W-1] ? -w_c[l] : w_c[l];
                    r_rem[l] <= '0;
                end
            end
            vfpf_pkg::F_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                for (int l = 0; l < 3; l++) begin
                    r_rem[l] <= w_ge[l]
                        ? vfpf_pkg::SIZE_W'(w_remw[l] - {1'b0, r_size})
                        : w_remw[l][vfpf_pkg::SIZE_W-1:0];
                    r_dvd[l] <= {r_dvd[l][vfpf_pkg::COORD_W-2:0], w_ge[l]};
                end
            end
            vfpf_pkg::F_KEY: begin
                r_cnt <= '0;
                r_key <= w_key;
                r_g   <= w_g;
                r_c   <= vfpf_pkg::HASH_MULT;
                r_acc <= '0;
            end
            vfpf_pkg::F_HASH: begin
                // low product bits, one 7-bit slice of the multiplicand a step
                r_cnt <= r_cnt + 1'b1;
                r_acc <= r_acc + w_prod[vfpf_pkg::HASH_W-1:0];
                r_g   <= r_g >> vfpf_pkg::HASH_CHUNK;
                r_c   <= r_c << vfpf_pkg::HASH_CHUNK;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/vfpf_queue.sv =====
// Two-entry queue of classified items between front and back.
module vfpf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vfpf_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output logic [1:0]      o_count,
    output vfpf_pkg::t_item o_item
);

    vfpf_pkg::t_item r_mem [2];
    logic            r_wptr, r_rptr;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_count = r_cnt;
    assign o_item  = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

endmodule

// ===== hdl/vfpf_back.sv =====
// Back end: probes the seen-key table and decides whether a point is passed on.
module vfpf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  vfpf_pkg::t_item      i_item,
    input  logic                 i_out_busy,
    output logic                 o_q_pop,
    output vfpf_pkg::t_back_stat o_stat,
    output vfpf_pkg::t_result    o_res
);

    vfpf_pkg::t_back_state r_state, n_state;
    logic [vfpf_pkg::ADDR_W-1:0]  r_clr_addr;
    logic [vfpf_pkg::EPOCH_W-1:0] r_epoch;
    logic                         r_resume;
    logic                         r_init;
    vfpf_pkg::t_item              r_item;
    logic [vfpf_pkg::ADDR_W-1:0]  r_slot;
    logic [vfpf_pkg::PROBE_W-1:0] r_probes;
    logic                         r_full;

    logic                         w_we;
    logic [vfpf_pkg::ADDR_W-1:0]  w_waddr;
    logic [vfpf_pkg::ENTRY_W-1:0] w_wdata, w_rdata;
    logic [vfpf_pkg::EPOCH_W-1:0] w_tag;
    logic                         w_free, w_hit, w_last_probe, w_clr_last, w_roll;

    vfpf_ram #(
        .WIDTH (vfpf_pkg::ENTRY_W),
        .DEPTH (vfpf_pkg::SEEN_DEPTH)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    // entry is live only if tagged with the current epoch
    assign w_tag        = w_rdata[vfpf_pkg::ENTRY_W-1 -: vfpf_pkg::EPOCH_W];
    assign w_free       = (w_tag != r_epoch);
    assign w_hit        = !w_free && (w_rdata[vfpf_pkg::KEY_W-1:0] == r_item.key);
    assign w_last_probe = (r_probes == vfpf_pkg::PROBE_W'(vfpf_pkg::SEEN_DEPTH - 1));
    assign w_clr_last   = (r_clr_addr == '1);
    assign w_roll       = i_item.cloud_start && (r_epoch == vfpf_pkg::EPOCH_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vfpf_pkg::B_CLEAR: if (w_clr_last)
                n_state = r_resume ? vfpf_pkg::B_PROBE : vfpf_pkg::B_IDLE;
            vfpf_pkg::B_IDLE: if (!i_q_empty)
                n_state = w_roll ? vfpf_pkg::B_CLEAR : vfpf_pkg::B_PROBE;
            vfpf_pkg::B_PROBE: n_state = vfpf_pkg::B_CHECK;
            vfpf_pkg::B_CHECK: begin
                if (w_free)             n_state = vfpf_pkg::B_EMIT;
                else if (w_hit)         n_state = vfpf_pkg::B_IDLE;
                else if (w_last_probe)  n_state = vfpf_pkg::B_EMIT;
                else                    n_state = vfpf_pkg::B_PROBE;
            end
            vfpf_pkg::B_EMIT: if (!i_out_busy) n_state = vfpf_pkg::B_IDLE;
            default: n_state = vfpf_pkg::B_IDLE;
        endcase
    end

    // outputs and table write port
    always_comb begin
        o_q_pop     = (r_state == vfpf_pkg::B_IDLE) && !i_q_empty;
        o_stat.init = r_init;
        o_stat.emit = (r_state == vfpf_pkg::B_EMIT) && !i_out_busy;
        o_res.x     = r_item.x;
        o_res.y     = r_item.y;
        o_res.z     = r_item.z;
        o_res.stamp = r_item.stamp;
        o_res.key   = r_item.key;
        o_res.full  = r_full;
        w_we        = 1'b0;
        w_waddr     = r_slot;
        w_wdata     = {r_epoch, r_item.key};
        unique case (r_state)
            vfpf_pkg::B_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = {vfpf_pkg::EPOCH_NONE, r_item.key};
            end
            vfpf_pkg::B_CHECK: w_we = w_free;
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= vfpf_pkg::B_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= vfpf_pkg::EPOCH_FIRST;
            r_resume   <= 1'b0;
            r_init     <= 1'b1;
        end else begin
            r_state <= n_state;
            case (r_state)
                vfpf_pkg::B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (w_clr_last) r_init <= 1'b0;
                end
                vfpf_pkg::B_IDLE: begin
                    if (!i_q_empty && i_item.cloud_start) begin
                        // new cloud: bump epoch, sweep the table when it wraps
                        r_clr_addr <= '0;
                        r_resume   <= 1'b1;
                        r_epoch    <= w_roll ? vfpf_pkg::EPOCH_FIRST : r_epoch + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // item and probe registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            vfpf_pkg::B_IDLE: begin
                r_item   <= i_item;
                r_slot   <= i_item.slot;
                r_probes <= '0;
            end
            vfpf_pkg::B_CHECK: begin
                r_full   <= !w_free;
                r_slot   <= r_slot + 1'b1;
                r_probes <= r_probes + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sim/voxel_first_point_filter_tb.sv =====
// Self-checking testbench for the voxel first-point filter.
module voxel_first_point_filter_tb;

    localparam int  TABLE_DEPTH  = 4096;
    localparam int  SETTLE_CYCLES = 9000;
    localparam int  CYCLE_LIMIT   = 3000000;
    localparam int  MAX_REPORTS   = 10;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                push;
    logic                                full;
    logic signed [vfpf_pkg::COORD_W-1:0] i_coord_x;
    logic signed [vfpf_pkg::COORD_W-1:0] i_coord_y;
    logic signed [vfpf_pkg::COORD_W-1:0] i_coord_z;
    logic [vfpf_pkg::COORD_W-1:0]        i_stamp;
    logic                                i_cloud_start;
    logic                                empty;
    logic                                pop;
    logic signed [vfpf_pkg::COORD_W-1:0] o_out_x;
    logic signed [vfpf_pkg::COORD_W-1:0] o_out_y;
    logic signed [vfpf_pkg::COORD_W-1:0] o_out_z;
    logic [vfpf_pkg::COORD_W-1:0]        o_out_stamp;
    logic [vfpf_pkg::KEY_W-1:0]          o_voxel_key;
    logic                                o_store_full;
    logic                                i_cfg_we;
    logic [vfpf_pkg::SIZE_W-1:0]         i_cfg_data;

    // Predictor state
    logic [vfpf_pkg::SIZE_W-1:0] model_size;
    logic [vfpf_pkg::KEY_W-1:0]  seen_key_tbl [TABLE_DEPTH];
    bit                          seen_vld_tbl [TABLE_DEPTH];
    int                          seen_total;
    vfpf_pkg::t_result           passed_points [$];

    int  mismatches;
    int  cycle_count;
    int  burst_left;
    int  stall_left;

    voxel_first_point_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_stamp       (i_stamp),
        .i_cloud_start (i_cloud_start),
        .empty         (empty),
        .pop           (pop),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_stamp   (o_out_stamp),
        .o_voxel_key   (o_voxel_key),
        .o_store_full  (o_store_full),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Floor division, bias, wrap to the index width
    function automatic logic [vfpf_pkg::IDX_W-1:0] axis_index(
            input logic signed [vfpf_pkg::COORD_W-1:0] c, input longint sz);
        longint cv;
        longint q;
        longint t;
        cv = longint'(c);
        if (cv >= 0) q = cv / sz;
        else q = -((-cv + sz - 1) / sz);
        t = q + (longint'(1) << (vfpf_pkg::IDX_W - 1));
        return t[vfpf_pkg::IDX_W-1:0];
    endfunction

    function automatic int home_slot(input logic [vfpf_pkg::KEY_W-1:0] key);
        logic [63:0] h;
        logic [63:0] k;
        k = {1'b0, key};
        h = k ^ (k >> 21) ^ (k >> 42);
        h = h * 64'h9E3779B97F4A7C15;
        h = h ^ (h >> 29);
        return int'(h[vfpf_pkg::ADDR_W-1:0]);
    endfunction

    // Track the seen table and queue the point if it is the first in its voxel
    task automatic predict_point(input logic signed [vfpf_pkg::COORD_W-1:0] x,
                                 input logic signed [vfpf_pkg::COORD_W-1:0] y,
                                 input logic signed [vfpf_pkg::COORD_W-1:0] z,
                                 input logic [vfpf_pkg::COORD_W-1:0] stamp,
                                 input logic cs);
        longint                     sz;
        logic [vfpf_pkg::KEY_W-1:0] key;
        int                         slot;
        bit                         found;
        bit                         have_free;
        int                         free_slot;
        vfpf_pkg::t_result          r;
        found = 0;
        have_free = 0;
        free_slot = 0;
        if (cs) begin
            for (int i = 0; i < TABLE_DEPTH; i++) seen_vld_tbl[i] = 0;
            seen_total = 0;
        end
        sz = (model_size == 0) ? 1 : longint'(model_size);
        key = {axis_index(z, sz), axis_index(y, sz), axis_index(x, sz)};
        slot = home_slot(key);
        for (int p = 0; p < TABLE_DEPTH; p++) begin
            if (!seen_vld_tbl[slot]) begin
                have_free = 1;
                free_slot = slot;
                break;
            end
            if (seen_key_tbl[slot] == key) begin
                found = 1;
                break;
            end
            slot = (slot + 1) % TABLE_DEPTH;
        end
        if (!found) begin
            r.x = x;
            r.y = y;
            r.z = z;
            r.stamp = stamp;
            r.key = key;
            r.full = 1'b1;
            if (have_free && seen_total < TABLE_DEPTH) begin
                seen_key_tbl[free_slot] = key;
                seen_vld_tbl[free_slot] = 1;
                seen_total++;
                r.full = 1'b0;
            end
            passed_points = {passed_points, r};
        end
    endtask

    // Send one item; bursts of random length separated by random gaps
    task automatic send_point(input logic signed [vfpf_pkg::COORD_W-1:0] x,
                              input logic signed [vfpf_pkg::COORD_W-1:0] y,
                              input logic signed [vfpf_pkg::COORD_W-1:0] z,
                              input logic [vfpf_pkg::COORD_W-1:0] stamp,
                              input logic cs);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        push          <= 1'b1;
        i_coord_x     <= x;
        i_coord_y     <= y;
        i_coord_z     <= z;
        i_stamp       <= stamp;
        i_cloud_start <= cs;
        do @(posedge i_clk); while (full);
        predict_point(x, y, z, stamp, cs);
        burst_left--;
    endtask

    // Stop sending, wait for every result, then let dropped items finish
    task automatic wait_quiet();
        push <= 1'b0;
        burst_left = 0;
        while (passed_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [vfpf_pkg::SIZE_W-1:0] v);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_size = v;
    endtask

    task automatic send_random_point(input logic [vfpf_pkg::SIZE_W-1:0] sz);
        logic signed [vfpf_pkg::COORD_W-1:0] c [3];
        int span;
        span = (sz == 0) ? 4 : 4 * int'(sz);
        if (span > 1 << 24) span = 1 << 24;
        for (int a = 0; a < 3; a++) begin
            case ($urandom_range(0, 9))
                0, 1:    c[a] = $urandom;
                2:       c[a] = $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                                     : 32'sh80000000 + $urandom_range(0, 3);
                default: c[a] = $urandom_range(0, 2 * span) - span;
            endcase
        end
        send_point(c[0], c[1], c[2], $urandom, $urandom_range(0, 29) == 0);
    endtask

    // Extremes, rounding of negatives, duplicates, wrap and zero size
    task automatic test_directed();
        send_point(0, 0, 0, 32'h0, 1'b1);
        send_point(511, 1, 2, 32'hFFFFFFFF, 1'b0);
        send_point(-1, 0, 0, 32'h1, 1'b0);
        send_point(-512, 0, 0, 32'h2, 1'b0);
        send_point(-513, 0, 0, 32'h3, 1'b0);
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'hA5A5A5A5, 1'b0);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h5A5A5A5A, 1'b0);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 0, 32'h4, 1'b0);
        send_point(0, 0, 0, 32'h5, 1'b0);
        send_point(0, 0, 0, 32'h6, 1'b1);
        write_size(20'd0);
        send_point(0, 0, 0, 32'h7, 1'b1);
        send_point(1 << 20, 0, 0, 32'h8, 1'b0);
        send_point(-(1 << 20), 0, 0, 32'h9, 1'b0);
        send_point(1 << 21, 0, 0, 32'hA, 1'b0);
        send_point(-1, -1, -1, 32'hB, 1'b0);
        write_size(20'hFFFFF);
        send_point(32'sh7FFFFFFF, 0, 32'sh80000000, 32'hC, 1'b1);
        send_point(-20'hFFFFF, 20'hFFFFF, 0, 32'hD, 1'b0);
        send_point(-(1 << 20), 1 << 20, 0, 32'hE, 1'b0);
        send_point(-20'hFFFFF, 20'hFFFFE, 0, 32'hF, 1'b0);
    endtask

    // Random points across several voxel sizes, extremes included
    task automatic test_random();
        logic [vfpf_pkg::SIZE_W-1:0] sizes [6];
        sizes = '{20'd1, 20'hFFFFF, 20'd512, 20'd0, 20'd37, 20'd0};
        sizes[5] = vfpf_pkg::SIZE_W'($urandom_range(1, 20'hFFFFF));
        for (int ph = 0; ph < 6; ph++) begin
            write_size(sizes[ph]);
            for (int n = 0; n < 120; n++) send_random_point(sizes[ph]);
        end
    endtask

    // Result checker and stall pattern of the receiver
    always @(posedge i_clk) begin
        vfpf_pkg::t_result e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && pop && !empty) begin
            if (passed_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected item: key %h stamp %h", o_voxel_key, o_out_stamp);
            end else begin
                e = passed_points.pop_front();
                if (e.x !== o_out_x || e.y !== o_out_y || e.z !== o_out_z ||
                    e.stamp !== o_out_stamp || e.key !== o_voxel_key ||
                    e.full !== o_store_full) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: exp x %h y %h z %h st %h key %h full %b",
                                  " / got x %h y %h z %h st %h key %h full %b"},
                                 e.x, e.y, e.z, e.stamp, e.key, e.full, o_out_x, o_out_y,
                                 o_out_z, o_out_stamp, o_voxel_key, o_store_full);
                end
            end
        end
        if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else begin
            pop <= 1'b1;
            case ($urandom_range(0, 63))
                0:          stall_left = $urandom_range(100, 400);
                1, 2, 3, 4: stall_left = $urandom_range(1, 20);
                default:    stall_left = 0;
            endcase
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_coord_x     = '0;
        i_coord_y     = '0;
        i_coord_z     = '0;
        i_stamp       = '0;
        i_cloud_start = 1'b0;
        pop           = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        model_size    = vfpf_pkg::VOXEL_SIZE_RESET;
        seen_total    = 0;
        mismatches    = 0;
        cycle_count   = 0;
        burst_left    = 0;
        stall_left    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) seen_vld_tbl[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random();
        wait_quiet();

        if (mismatches == 0 && passed_points.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
